@@ rtl/mdsc_pkg.sv @@
package mdsc_pkg;

    localparam int COUNT_W   = 16;
    localparam int REFW_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [REFW_W-1:0]  REFW_RESET   = 2'd1;
    localparam logic [APB_AW-1:0]  ADDR_REFW    = 3'd0;

    // Descriptor characters.
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h28;  // (
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h29;  // )
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;  // ;
    localparam logic [BYTE_W-1:0] CH_ARRAY = 8'h5B;  // [
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
    localparam logic [BYTE_W-1:0] CH_J     = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;

    typedef struct packed {
        logic               seeking_open;
        logic               in_class_name;
        logic               array_pending;
        logic [COUNT_W-1:0] word_total;
        logic               answered;
        logic               pos_nonzero;
    } t_scan_state;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic [COUNT_W-1:0] count;
    } t_scan_result;

    localparam t_scan_state SCAN_CLEAR = '{
        seeking_open:  1'b1,
        in_class_name: 1'b0,
        array_pending: 1'b0,
        word_total:    '0,
        answered:      1'b0,
        pos_nonzero:   1'b0
    };

endpackage

@@ rtl/mdsc_if.sv @@
interface mdsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] desc_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output desc_byte, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input desc_byte, input first_byte, input last_byte,
                    output ready);
endinterface

interface mdsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] slot_count;
    logic        bad_descriptor;

    modport source (output valid, output slot_count, output bad_descriptor, input ready);
    modport sink   (input valid, input slot_count, input bad_descriptor, output ready);
endinterface

@@ rtl/mdsc_cfg.sv @@
module mdsc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mdsc_pkg::APB_AW-1:0]  paddr,
    input  logic [mdsc_pkg::APB_DW-1:0]  pwdata,
    output logic [mdsc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [mdsc_pkg::REFW_W-1:0]  o_ref_words
);
    import mdsc_pkg::*;

    logic [REFW_W-1:0] r_ref_words;
    logic              hit;

    // Only the word address matters; the low byte-lane bits are ignored.
    assign hit    = (paddr[APB_AW-1:2] == ADDR_REFW[APB_AW-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_words <= REFW_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_ref_words <= pwdata[REFW_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata[REFW_W-1:0] = r_ref_words;
        end
    end

    assign o_ref_words = r_ref_words;

endmodule

@@ rtl/mdsc_step.sv @@
module mdsc_step (
    input  mdsc_pkg::t_scan_state         i_state,
    input  logic [mdsc_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_first,
    input  logic                          i_last,
    input  logic [mdsc_pkg::REFW_W-1:0]   i_ref_words,
    output mdsc_pkg::t_scan_state         o_state,
    output mdsc_pkg::t_scan_result        o_result
);
    import mdsc_pkg::*;

    t_scan_state      s;
    logic [COUNT_W:0] sum;
    logic [REFW_W-1:0] add;
    logic             do_add;
    logic             emit;
    logic             emit_bad;

    always_comb begin
        s        = i_first ? SCAN_CLEAR : i_state;
        add      = '0;
        do_add   = 1'b0;
        emit     = 1'b0;
        emit_bad = 1'b0;

        if (s.answered) begin
            // Idle until the next descriptor starts.
        end else if (i_last) begin
            emit     = 1'b1;
            emit_bad = 1'b1;
        end else begin
            s.pos_nonzero = 1'b1;
            if (s.in_class_name) begin
                if (i_byte == CH_SEMI) begin
                    s.in_class_name = 1'b0;
                end
            end else if (s.seeking_open) begin
                if (i_byte == CH_OPEN) begin
                    if (i_state.pos_nonzero && !i_first) begin
                        emit     = 1'b1;
                        emit_bad = 1'b1;
                    end else begin
                        s.seeking_open = 1'b0;
                    end
                end
            end else if (i_byte == CH_CLOSE) begin
                emit     = 1'b1;
                emit_bad = s.array_pending;
            end else begin
                unique case (i_byte)
                    CH_B, CH_C, CH_F, CH_I, CH_S, CH_Z: begin
                        do_add          = 1'b1;
                        add             = s.array_pending ? i_ref_words : REFW_W'(1);
                        s.array_pending = 1'b0;
                    end
                    CH_D, CH_J: begin
                        do_add          = 1'b1;
                        add             = s.array_pending ? i_ref_words : REFW_W'(2);
                        s.array_pending = 1'b0;
                    end
                    CH_L: begin
                        do_add          = 1'b1;
                        add             = i_ref_words;
                        s.array_pending = 1'b0;
                        s.in_class_name = 1'b1;
                    end
                    CH_ARRAY: begin
                        s.array_pending = 1'b1;
                    end
                    default: begin
                        emit     = 1'b1;
                        emit_bad = 1'b1;
                    end
                endcase
            end
        end

        sum = {1'b0, s.word_total} + (COUNT_W+1)'(add);
        if (do_add) begin
            s.word_total = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end
        if (emit) begin
            s.answered = 1'b1;
        end

        o_state        = s;
        o_result.valid = emit;
        o_result.bad   = emit_bad;
        o_result.count = emit_bad ? '0 : s.word_total;
    end

endmodule

@@ rtl/method_descriptor_slot_counter.sv @@
// Method descriptor slot counter. Descriptor bytes arrive one per request on i_desc,
// with first_byte marking the start of a descriptor and last_byte its final byte, and
// the block returns at most one result per descriptor on o_slot: the number of stack
// words the parameter list takes (saturating at 65535) or a malformed flag with a zero
// count. A byte can be taken every clock cycle; each byte passes one scan step held
// between an input register and a result register, and a stalled result side holds
// bytes back only once both registers are full. The APB register at address 0 sets the
// words per object reference.
module method_descriptor_slot_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mdsc_in_if.sink                      i_desc,
    mdsc_out_if.source                   o_slot,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mdsc_pkg::APB_AW-1:0]  paddr,
    input  logic [mdsc_pkg::APB_DW-1:0]  pwdata,
    output logic [mdsc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import mdsc_pkg::*;

    logic [REFW_W-1:0] ref_words;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_in_last;

    t_scan_state       r_state;
    t_scan_state       n_state;
    t_scan_result      step_res;

    logic               r_out_valid;
    logic               r_out_bad;
    logic [COUNT_W-1:0] r_out_count;

    logic advance;
    logic take;

    mdsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_ref_words (ref_words)
    );

    mdsc_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .i_last      (r_in_last),
        .i_ref_words (ref_words),
        .o_state     (n_state),
        .o_result    (step_res)
    );

    // The held byte moves on unless it makes a result while the result register is stuck.
    assign advance      = r_in_valid && (!step_res.valid || !r_out_valid || o_slot.ready);
    assign i_desc.ready = !r_in_valid || advance;
    assign take         = i_desc.valid && i_desc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte  <= i_desc.desc_byte;
            r_in_first <= i_desc.first_byte;
            r_in_last  <= i_desc.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_slot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_bad   <= step_res.bad;
            r_out_count <= step_res.count;
        end
    end

    assign o_slot.valid          = r_out_valid;
    assign o_slot.bad_descriptor = r_out_bad;
    assign o_slot.slot_count     = r_out_count;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> r_out_count == '0)
        else $error("malformed result carries a nonzero count");

    a_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_res.valid |=> r_state.answered)
        else $error("result issued without marking the descriptor answered");

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_state))
        else $error("held byte or scan state changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_desc.ready)
        else $error("input stalled with an empty result register");
`endif

endmodule

@@ verif/mdsc_score_pkg.sv @@
`timescale 1ns / 1ps

package mdsc_score_pkg;
    import mdsc_pkg::*;

    class slot_count_tracker;
        logic [REFW_W-1:0]  ref_words;
        logic               seeking_open;
        logic               in_class_name;
        logic               array_pending;
        logic [COUNT_W-1:0] word_total;
        logic               answered;
        logic               pos_nonzero;
        t_scan_result       expected_counts[$];
        int                 requests;
        int                 results;
        int                 bad_results;
        int                 saturated;
        int                 errors;

        function new();
            ref_words   = REFW_RESET;
            requests    = 0;
            results     = 0;
            bad_results = 0;
            saturated   = 0;
            errors      = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            seeking_open  = 1'b1;
            in_class_name = 1'b0;
            array_pending = 1'b0;
            word_total    = '0;
            answered      = 1'b0;
            pos_nonzero   = 1'b0;
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void add_words(logic [2:0] n);
            logic [COUNT_W:0] sum;
            sum = word_total + n;
            word_total = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
        endfunction

        // An element type that closes an array counts as one reference.
        function void add_scalar(logic [2:0] n);
            if (array_pending) begin
                add_words(3'(ref_words));
                array_pending = 1'b0;
            end else begin
                add_words(n);
            end
        endfunction

        function void push_count(logic bad);
            t_scan_result r;
            r.valid = 1'b1;
            r.bad   = bad;
            r.count = bad ? '0 : word_total;
            expected_counts.push_back(r);
            answered = 1'b1;
        endfunction

        function void scan_byte(logic [BYTE_W-1:0] c, logic first, logic last);
            logic late;
            requests++;
            if (first)
                clear_scan();
            if (answered)
                return;
            if (last) begin
                push_count(1'b1);
                return;
            end
            late = pos_nonzero;
            pos_nonzero = 1'b1;
            if (in_class_name) begin
                if (c == CH_SEMI)
                    in_class_name = 1'b0;
                return;
            end
            if (seeking_open) begin
                if (c == CH_OPEN) begin
                    if (late) begin
                        push_count(1'b1);
                        return;
                    end
                    seeking_open = 1'b0;
                end
                return;
            end
            if (c == CH_CLOSE) begin
                push_count(array_pending);
                return;
            end
            case (c)
                CH_B, CH_C, CH_F, CH_I, CH_S, CH_Z: add_scalar(3'd1);
                CH_D, CH_J: add_scalar(3'd2);
                CH_L: begin
                    array_pending = 1'b0;
                    add_words(3'(ref_words));
                    in_class_name = 1'b1;
                end
                CH_ARRAY: array_pending = 1'b1;
                default: push_count(1'b1);
            endcase
        endfunction

        function void check_slot(logic [COUNT_W-1:0] count, logic bad);
            t_scan_result want;
            results++;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result, count %0d bad %0b", $time, count, bad);
                errors++;
                return;
            end
            want = expected_counts.pop_front();
            if (bad !== want.bad) begin
                $display("%0t: bad_descriptor expected %0b actual %0b", $time, want.bad, bad);
                errors++;
            end
            if (count !== want.count) begin
                $display("%0t: slot_count expected %0d actual %0d", $time, want.count, count);
                errors++;
            end
            if (want.bad)
                bad_results++;
            else if (want.count == COUNT_MAX)
                saturated++;
        endfunction
    endclass

endpackage

@@ verif/method_descriptor_slot_counter_test.sv @@
`timescale 1ns / 1ps

module method_descriptor_slot_counter_test;
    import mdsc_pkg::*;
    import mdsc_score_pkg::*;

    localparam int         HALF_PERIOD  = 6;
    localparam int         RESET_CYCLES = 7;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         PHASE_ITEMS  = 130;
    localparam longint     TIMEOUT_NS   = 24_000_000;
    localparam logic [7:0] CH_VOID      = 8'h56;
    localparam logic [7:0] SCALAR_CODES [8] = '{CH_B, CH_C, CH_D, CH_F, CH_I, CH_J, CH_S, CH_Z};

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 send_idle_pct = 6;
    int                 recv_idle_pct = 61;
    int                 hold_off_asks = 0;
    int                 requests_sent = 0;
    logic [7:0]         desc_bytes[$];

    slot_count_tracker  sb = new();

    mdsc_in_if  desc_ch();
    mdsc_out_if slot_ch();

    method_descriptor_slot_counter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (desc_ch),
        .o_slot  (slot_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("method_descriptor_slot_counter_test NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (slot_ch.valid && slot_ch.ready)
                sb.check_slot(slot_ch.slot_count, slot_ch.bad_descriptor);
            if (desc_ch.valid && desc_ch.ready)
                sb.scan_byte(desc_ch.desc_byte, desc_ch.first_byte, desc_ch.last_byte);
        end
    end

    // Result side: random stalls, plus one long hold-off when the main flow asks for it.
    initial begin
        int stall_left;
        int holds_seen;
        stall_left = 0;
        holds_seen = 0;
        slot_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_asks != holds_seen) begin
                holds_seen = hold_off_asks;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                slot_ch.ready <= 1'b0;
            end else begin
                slot_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic [7:0] c, input logic f, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            desc_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        desc_ch.valid      <= 1'b1;
        desc_ch.desc_byte  <= c;
        desc_ch.first_byte <= f;
        desc_ch.last_byte  <= l;
        @(posedge i_clk);
        while (!desc_ch.ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic send_descriptor(input logic mark_first);
        for (int k = 0; k < desc_bytes.size(); k++)
            send_request(desc_bytes[k], (k == 0) ? mark_first : 1'b0,
                         k == desc_bytes.size() - 1);
    endtask

    task automatic append_text(input string s);
        for (int k = 0; k < s.len(); k++)
            desc_bytes.push_back(s[k]);
    endtask

    // A well-formed descriptor: parameters of random kinds, class names of random bytes,
    // sometimes a few ignored bytes after the closing paren.
    task automatic build_descriptor(input int max_params);
        logic [7:0] b;
        desc_bytes.delete();
        desc_bytes.push_back(CH_OPEN);
        repeat ($urandom_range(max_params)) begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) desc_bytes.push_back(CH_ARRAY);
            if ($urandom_range(9) < 8) begin
                desc_bytes.push_back(SCALAR_CODES[$urandom_range(7)]);
            end else begin
                desc_bytes.push_back(CH_L);
                repeat ($urandom_range(4)) begin
                    b = 8'($urandom_range(255));
                    desc_bytes.push_back((b == CH_SEMI) ? 8'h00 : b);
                end
                desc_bytes.push_back(CH_SEMI);
            end
        end
        desc_bytes.push_back(CH_CLOSE);
        repeat ($urandom_range(2)) desc_bytes.push_back(8'($urandom_range(255)));
        desc_bytes.push_back(($urandom_range(1) == 0) ? CH_VOID : SCALAR_CODES[$urandom_range(7)]);
    endtask

    task automatic settle();
        desc_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reference_words(input logic [REFW_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_REFW;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.ref_words = value;
        // Read the register back.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[REFW_W-1:0] !== value) begin
            $display("%0t: reference_words readback expected %0d actual %0d",
                     $time, value, prdata[REFW_W-1:0]);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random_phase();
        int start;
        int kind;
        start = requests_sent;
        while (requests_sent - start < PHASE_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 88) begin
                build_descriptor(6);
                if (kind >= 70) begin
                    case ($urandom_range(2))
                        0: desc_bytes[$urandom_range(desc_bytes.size() - 1)] =
                               8'($urandom_range(255));
                        1: repeat ($urandom_range(1, desc_bytes.size() - 1))
                            void'(desc_bytes.pop_back());
                        default: desc_bytes.push_front(8'($urandom_range(255)));
                    endcase
                end
                send_descriptor(1'b1);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_request(8'($urandom_range(255)), $urandom_range(2) == 0,
                                 $urandom_range(4) == 0);
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        desc_ch.valid      <= 1'b0;
        desc_ch.desc_byte  <= '0;
        desc_ch.first_byte <= 1'b0;
        desc_ch.last_byte  <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Parsing starts straight out of reset, so the first descriptor has no first flag.
        desc_bytes.delete();
        append_text("(BCDFIJSZ[L");
        desc_bytes.push_back(8'h00);
        desc_bytes.push_back(8'hFF);
        append_text(";)V");
        send_descriptor(1'b0);
        desc_bytes.delete();
        append_text("x(V");
        send_descriptor(1'b1);
        desc_bytes.delete();
        append_text("(()");
        send_descriptor(1'b1);
        desc_bytes.delete();
        append_text("([)V");
        send_descriptor(1'b1);
        desc_bytes.delete();
        append_text("(I");
        send_descriptor(1'b1);
        send_request(CH_OPEN, 1'b1, 1'b1);

        settle();
        program_reference_words(2'd3);
        run_random_phase();

        settle();
        send_idle_pct = 61;
        recv_idle_pct = 6;
        program_reference_words(2'd0);
        run_random_phase();

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_reference_words(2'd2);
        hold_off_asks <= hold_off_asks + 1;
        repeat (24) begin
            build_descriptor(1);
            send_descriptor(1'b1);
        end
        run_random_phase();

        settle();
        $display("Scanned %0d descriptor bytes, %0d results checked (%0d malformed, %0d saturated),",
                 sb.requests, sb.results, sb.bad_results, sb.saturated);
        $display("with reference widths 0 to 3, random stalls on both sides and a long output hold-off.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("method_descriptor_slot_counter_test OK");
        end else begin
            $display("method_descriptor_slot_counter_test NOT OK");
        end
        $finish;
    end

endmodule
